// ----- hdl/lbas_pkg.sv -----
// Shared types and constants of the line block Adler signer.
package lbas_pkg;

	// Adler-32 arithmetic.
	localparam logic [15:0] ADLER_MOD   = 16'd65521;
	localparam logic [31:0] SHORT_MARK  = 32'hfff1_fff1;
	localparam logic [6:0]  SHORT_LIMIT = 7'd4;

	// Register reset values.
	localparam logic [6:0] MAX_LEN_RST = 7'h7f;
	localparam logic [7:0] DELIM_RST   = 8'h0a;

	// Register map: index is byte address bit 2.
	localparam int unsigned ADDR_W = 3;
	localparam logic REG_MAX_LEN = 1'b0;
	localparam logic REG_DELIM   = 1'b1;

	// Output beat layout.
	localparam int unsigned OUT_DATA_W = 136;

	typedef struct packed {
		logic [6:0] max_len;
		logic [7:0] delim;
	} cfg_t;

	typedef struct packed {
		logic [15:0] sum_high;
		logic [15:0] sum_low;
	} adler_t;

endpackage

// ----- hdl/line_block_adler_signer.sv -----
// Top level of the line block Adler signer: block cutting, signing and result register.
//
// The block takes one byte per clock cycle, continuously, for as long as results are
// taken. A byte is captured in an input register; as it leaves that register, the block state
// (position, length, Adler sums and counters) is updated from it and, if the byte closes
// a block, the finished block is written into the result register. A result is therefore
// presented from the result register once its closing byte has left the input
// register. The rate of one byte per cycle, while results are taken,
// is set by the Adler update, two additions with a conditional subtract each, which
// is combinational. When the result register is full and not being taken,
// a byte that closes a block waits in the input register and s_axis_tready falls; bytes
// that do not close a block still pass through. A block closes after the delimiter
// byte, after max_block_len bytes (zero acts as one), or at the byte marked tlast;
// after the tlast block the offset, block index and significant count restart from
// zero. Blocks of four bytes or fewer carry the marker 0xfff1fff1 and are flagged not
// significant. The registers are to be written only while the block is idle. No memory
// is used, so the block is ready straight after reset.
module line_block_adler_signer (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Input stream
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [7:0]                             s_axis_tdata,  // [7:0] data_byte
	input  logic                                   s_axis_tlast,  // last_byte
	// Result stream
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// [31:0] block_offset, [38:32] block_length, [70:39] block_number,
	// [102:71] signature, [134:103] significant_count, [135] zero
	output logic [lbas_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
	output logic                                   m_axis_tuser,  // significant
	// Configuration port
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [lbas_pkg::ADDR_W-1:0]            paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);
	import lbas_pkg::*;

	cfg_t cfg;

	lbas_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Block state.
	logic [31:0] pos_q;
	logic [31:0] start_q;
	logic [6:0]  len_q;
	adler_t      sums_q;
	logic [31:0] blocks_q;
	logic [31:0] sig_done_q;

	// Result register.
	logic        valid_s2;
	logic [31:0] offset_s2;
	logic [6:0]  length_s2;
	logic [31:0] number_s2;
	logic [31:0] signature_s2;
	logic        sig_s2;
	logic [31:0] sig_count_s2;

	// Update logic.
	adler_t      sums_nxt;
	logic [31:0] start_eff;
	logic [6:0]  len_nxt;
	logic [6:0]  limit;
	logic        closes;
	logic        sig;
	logic [31:0] sig_count;
	logic        s2_free;
	logic        advance;

	lbas_adler_step u_adler (
		.cur       (sums_q),
		.data_byte (byte_s1),
		.nxt       (sums_nxt)
	);

	always_comb begin
		start_eff = (len_q == 7'd0) ? pos_q : start_q;
		len_nxt   = len_q + 7'd1;
		limit     = (cfg.max_len == 7'd0) ? 7'd1 : cfg.max_len;
		closes    = (byte_s1 == cfg.delim) || (len_nxt >= limit) || last_s1;
		sig       = len_nxt > SHORT_LIMIT;
		sig_count = sig_done_q + {31'd0, sig};
	end

	// A byte that does not close a block never needs the result register.
	assign s2_free       = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && (!closes || s2_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= 32'd0;
			start_q    <= 32'd0;
			len_q      <= 7'd0;
			sums_q     <= '{sum_high: 16'd0, sum_low: 16'd1};
			blocks_q   <= 32'd0;
			sig_done_q <= 32'd0;
		end else if (advance) begin
			start_q <= start_eff;
			if (closes) begin
				len_q      <= 7'd0;
				sums_q     <= '{sum_high: 16'd0, sum_low: 16'd1};
				pos_q      <= last_s1 ? 32'd0 : pos_q + 32'd1;
				blocks_q   <= last_s1 ? 32'd0 : blocks_q + 32'd1;
				sig_done_q <= last_s1 ? 32'd0 : sig_count;
			end else begin
				len_q  <= len_nxt;
				sums_q <= sums_nxt;
				pos_q  <= pos_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= advance && closes;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && closes) begin
			offset_s2    <= start_eff;
			length_s2    <= len_nxt;
			number_s2    <= blocks_q;
			signature_s2 <= sig ? {sums_nxt.sum_high, sums_nxt.sum_low} : SHORT_MARK;
			sig_s2       <= sig;
			sig_count_s2 <= sig_count;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, sig_count_s2, signature_s2, number_s2, length_s2, offset_s2};
	assign m_axis_tuser  = sig_s2;

	// An open block with no bytes holds the Adler seed.
	a_seed_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q == 7'd0) |-> (sums_q.sum_low == 16'd1 && sums_q.sum_high == 16'd0))
		else $error("empty block does not hold the Adler seed");

	// Both sums stay reduced below the modulus.
	a_sums_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(sums_q.sum_low < ADLER_MOD) && (sums_q.sum_high < ADLER_MOD))
		else $error("Adler sum not reduced");

	// The significant flag agrees with the length and with the signature marker.
	a_sig_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((sig_s2 == (length_s2 > SHORT_LIMIT)) &&
			      (sig_s2 == (signature_s2 != SHORT_MARK)) && (length_s2 != 7'd0)))
		else $error("significant flag inconsistent with result");

	// A result waiting in the output register is not overwritten.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_axis_tready) |=> (valid_s2 && $stable(offset_s2) &&
						  $stable(signature_s2)))
		else $error("pending result changed");

endmodule

// ----- hdl/lbas_cfg_regs.sv -----
// Configuration registers of the line block Adler signer behind the APB port.
module lbas_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lbas_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	output lbas_pkg::cfg_t               cfg
);
	import lbas_pkg::*;

	logic [6:0] max_len_q;
	logic [7:0] delim_q;
	logic       wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RST;
			delim_q   <= DELIM_RST;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_MAX_LEN: max_len_q <= pwdata[6:0];
				REG_DELIM:   delim_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MAX_LEN: prdata = {25'd0, max_len_q};
			REG_DELIM:   prdata = {24'd0, delim_q};
			default:     prdata = 32'd0;
		endcase
	end

	assign cfg.max_len = max_len_q;
	assign cfg.delim   = delim_q;

endmodule

// ----- hdl/lbas_adler_step.sv -----
// One-byte Adler-32 update: two additions, each reduced by a single subtract.
module lbas_adler_step (
	input  lbas_pkg::adler_t cur,
	input  logic [7:0]       data_byte,
	output lbas_pkg::adler_t nxt
);
	import lbas_pkg::*;

	logic [16:0] low_sum;
	logic [16:0] high_sum;
	logic [15:0] low_red;

	always_comb begin
		low_sum  = {1'b0, cur.sum_low} + {9'd0, data_byte};
		low_red  = (low_sum >= {1'b0, ADLER_MOD}) ? 16'(low_sum - {1'b0, ADLER_MOD})
							  : low_sum[15:0];
		high_sum = {1'b0, cur.sum_high} + {1'b0, low_red};
		nxt.sum_low  = low_red;
		nxt.sum_high = (high_sum >= {1'b0, ADLER_MOD}) ? 16'(high_sum - {1'b0, ADLER_MOD})
							      : high_sum[15:0];
	end

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the line block Adler signer: byte stream in, block results out.
`timescale 1ns / 100ps

module tb;
	import lbas_pkg::*;

	localparam int unsigned LIMIT = 600000;
	localparam logic [ADDR_W-1:0] ADDR_MAX_LEN = {REG_MAX_LEN, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_DELIM   = {REG_DELIM, 2'b00};
	localparam int N_PHASES = 7;

	// Result beat as it leaves on m_axis_tdata, most significant field first.
	typedef struct packed {
		logic        pad;
		logic [31:0] sig_count;
		logic [31:0] signature;
		logic [31:0] number;
		logic [6:0]  length;
		logic [31:0] offset;
	} block_beat_t;

	typedef struct packed {
		block_beat_t beat;
		logic        significant;
	} block_sig_t;

	// One row of the directed part; known rows carry a hand-worked result.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       known;
		block_sig_t lit;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;  // [7:0] data_byte
	logic s_axis_tlast = 1'b0;      // last_byte
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// [31:0] block_offset, [38:32] block_length, [70:39] block_number,
	// [102:71] signature, [134:103] significant_count, [135] zero
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;             // significant
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	line_block_adler_signer dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow copy of the registers and of the block cutter's state.
	logic [6:0] cfg_max_len = MAX_LEN_RST;
	logic [7:0] cfg_delim = DELIM_RST;
	logic [31:0] stream_pos = '0;
	logic [31:0] blk_start = '0;
	logic [6:0] blk_len = '0;
	int unsigned sum_a = 1;
	int unsigned sum_b = 0;
	logic [31:0] blk_done = '0;
	logic [31:0] sig_done = '0;

	block_sig_t block_q[$];
	dir_row_t lit_q[$];
	dir_row_t steps[19];
	int fails = 0;
	bit idle_on = 1'b1;
	int unsigned cycles = 0;

	// Feeds one byte through the block cutter; returns 1 when it closes a block.
	function automatic bit sign_byte(input logic [7:0] d, input logic l,
			output block_sig_t res);
		logic [6:0] lim;
		lim = (cfg_max_len == 7'd0) ? 7'd1 : cfg_max_len;
		res = '0;
		if (blk_len == 7'd0)
			blk_start = stream_pos;
		sum_a += d;
		if (sum_a >= ADLER_MOD)
			sum_a -= ADLER_MOD;
		sum_b += sum_a;
		if (sum_b >= ADLER_MOD)
			sum_b -= ADLER_MOD;
		blk_len = blk_len + 7'd1;
		stream_pos = stream_pos + 32'd1;
		if (!(d == cfg_delim || blk_len >= lim || l))
			return 1'b0;
		res.significant = blk_len > SHORT_LIMIT;
		if (res.significant)
			sig_done = sig_done + 32'd1;
		res.beat.offset = blk_start;
		res.beat.length = blk_len;
		res.beat.number = blk_done;
		res.beat.signature = res.significant ? {sum_b[15:0], sum_a[15:0]} : SHORT_MARK;
		res.beat.sig_count = sig_done;
		blk_done = blk_done + 32'd1;
		blk_len = '0;
		sum_a = 1;
		sum_b = 0;
		// A stream end restarts offsets and counters; the registers stay.
		if (l) begin
			stream_pos = '0;
			blk_done = '0;
			sig_done = '0;
		end
		return 1'b1;
	endfunction

	function automatic block_sig_t blk_lit(input logic [31:0] off, input logic [6:0] len,
			input logic [31:0] num, input logic [31:0] sig, input logic s,
			input logic [31:0] cnt);
		blk_lit = '{'{1'b0, cnt, sig, num, len, off}, s};
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endfunction

	// Scoreboard: both handshakes are sampled at the clock edge that completes them.
	always @(posedge clk) begin : scoreboard
		block_sig_t pred;
		block_sig_t got;
		dir_row_t row;
		bit have_row;
		bit closed;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				have_row = lit_q.size() != 0;
				if (have_row)
					row = lit_q.pop_front();
				closed = sign_byte(s_axis_tdata, s_axis_tlast, pred);
				if (closed) begin
					if (have_row && row.known)
						pred = row.lit;
					block_q.push_back(pred);
				end else if (have_row && row.known) begin
					$error("directed byte %0h should have closed a block", row.data);
					fails++;
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.beat = m_axis_tdata;
				got.significant = m_axis_tuser;
				if (block_q.size() == 0) begin
					$error("block result with no block expected: %0h", m_axis_tdata);
					fails++;
				end else begin
					pred = block_q.pop_front();
					check_field("block_offset", pred.beat.offset, got.beat.offset);
					check_field("block_length", {25'd0, pred.beat.length},
						{25'd0, got.beat.length});
					check_field("block_number", pred.beat.number, got.beat.number);
					check_field("signature", pred.beat.signature, got.beat.signature);
					check_field("significant", {31'd0, pred.significant},
						{31'd0, got.significant});
					check_field("significant_count", pred.beat.sig_count,
						got.beat.sig_count);
					check_field("padding bit", {31'd0, pred.beat.pad},
						{31'd0, got.beat.pad});
				end
			end
		end
	end

	// Result side back-pressure: random stall bursts while idling is enabled.
	initial begin
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic l);
		if (idle_on && $urandom_range(0, 9) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tlast <= l;
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// The first edge lets the scoreboard book the last accepted byte.
	task automatic drain();
		@(posedge clk);
		while (block_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [31:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (a == ADDR_MAX_LEN)
			cfg_max_len = v[6:0];
		else if (a == ADDR_DELIM)
			cfg_delim = v[7:0];
		@(posedge clk);
	endtask

	task automatic apb_read(input logic [ADDR_W-1:0] a, input logic [31:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= a;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		check_field("register read", want, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Random lines: mostly short, some long enough to hit the length limit. Each
	// line usually ends on the delimiter, sometimes on a stream end, sometimes
	// simply runs on into the next one.
	task automatic run_lines(input int n, input int long_len, input bit heavy);
		int sent;
		int len;
		int kind;
		logic [7:0] d;
		logic l;
		sent = 0;
		while (sent < n) begin
			len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, long_len)
				: $urandom_range(1, 12);
			if (len > n - sent)
				len = n - sent;
			kind = $urandom_range(0, 9);
			for (int i = 0; i < len; i++) begin
				d = (heavy && $urandom_range(0, 1) == 1) ? 8'hff : 8'($urandom);
				l = 1'b0;
				if (i == len - 1) begin
					if (kind < 6)
						d = cfg_delim;
					else if (kind < 8)
						l = 1'b1;
				end else if (d == cfg_delim && $urandom_range(0, 3) != 0) begin
					d = ~d;
				end else if ($urandom_range(0, 49) == 0) begin
					l = 1'b1;
				end
				send_byte(d, l);
			end
			sent += len;
		end
		s_axis_tvalid <= 1'b0;
	endtask

	initial begin : stimulus
		// Per-phase settings; a negative value is drawn at random.
		int ph_max[N_PHASES] = '{0, 1, 127, 5, 4, -1, 127};
		int ph_delim[N_PHASES] = '{8'h00, 8'hff, 8'h00, 8'h41, -1, -1, 8'h0a};
		int ph_long[N_PHASES] = '{20, 20, 300, 30, 30, 150, 150};
		bit ph_heavy[N_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
		bit ph_idle[N_PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
		int mx;
		int dl;
		logic [31:0] v;

		// Directed part under reset settings (limit 127, delimiter line feed).
		steps = '{
			// A lone delimiter right after reset is a one-byte short block.
			'{8'h0a, 1'b0, 1'b1, blk_lit(32'd0, 7'd1, 32'd0, SHORT_MARK, 1'b0, 32'd0)},
			'{8'hff, 1'b0, 1'b0, '0},
			'{8'hff, 1'b0, 1'b0, '0},
			'{8'hff, 1'b0, 1'b0, '0},
			'{8'hff, 1'b0, 1'b0, '0},
			// Five bytes closed by the stream end: the shortest signed block.
			'{8'h00, 1'b1, 1'b1, blk_lit(32'd1, 7'd5, 32'd1, 32'h0df7_03fd, 1'b1, 32'd1)},
			// The stream has restarted: offset, index and count are back at zero.
			'{8'h0a, 1'b0, 1'b1, blk_lit(32'd0, 7'd1, 32'd0, SHORT_MARK, 1'b0, 32'd0)},
			'{8'h00, 1'b1, 1'b1, blk_lit(32'd1, 7'd1, 32'd1, SHORT_MARK, 1'b0, 32'd0)},
			'{8'h01, 1'b0, 1'b0, '0},
			'{8'h02, 1'b0, 1'b0, '0},
			'{8'h03, 1'b0, 1'b0, '0},
			// Four bytes is still short.
			'{8'h0a, 1'b0, 1'b1, blk_lit(32'd0, 7'd4, 32'd0, SHORT_MARK, 1'b0, 32'd0)},
			'{8'h80, 1'b0, 1'b0, '0},
			'{8'h7f, 1'b0, 1'b0, '0},
			'{8'h55, 1'b0, 1'b0, '0},
			'{8'haa, 1'b0, 1'b0, '0},
			'{8'h0a, 1'b0, 1'b0, '0},
			'{8'hff, 1'b1, 1'b0, '0},
			// The delimiter and the stream end on the same byte give one block.
			'{8'h0a, 1'b1, 1'b1, blk_lit(32'd0, 7'd1, 32'd0, SHORT_MARK, 1'b0, 32'd0)}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_read(ADDR_MAX_LEN, {25'd0, MAX_LEN_RST});
		apb_read(ADDR_DELIM, {24'd0, DELIM_RST});

		foreach (steps[i]) begin
			lit_q.push_back(steps[i]);
			send_byte(steps[i].data, steps[i].last);
		end
		s_axis_tvalid <= 1'b0;

		for (int p = 0; p < N_PHASES; p++) begin
			// Registers change only when the block is quiet: no result pending
			// and the last bytes through the two-stage pipeline.
			drain();
			repeat (4) @(posedge clk);
			idle_on = ph_idle[p];
			mx = (ph_max[p] < 0) ? $urandom_range(1, 127) : ph_max[p];
			dl = (ph_delim[p] < 0) ? $urandom_range(0, 255) : ph_delim[p];
			// Upper write data bits are junk; only the register width counts.
			v = $urandom;
			v[6:0] = mx[6:0];
			apb_write(ADDR_MAX_LEN, v);
			v = $urandom;
			v[7:0] = dl[7:0];
			apb_write(ADDR_DELIM, v);
			apb_read(ADDR_MAX_LEN, {25'd0, cfg_max_len});
			apb_read(ADDR_DELIM, {24'd0, cfg_delim});
			if (p == 5) begin
				// Let the result side run dry before carrying on.
				run_lines(110, ph_long[p], ph_heavy[p]);
				drain();
				run_lines(110, ph_long[p], ph_heavy[p]);
			end else begin
				run_lines(220, ph_long[p], ph_heavy[p]);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (block_q.size() != 0) begin
			$error("%0d block results never arrived", block_q.size());
			fails++;
		end
		if (fails == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ----- line_block_adler_signer.f -----
hdl/lbas_pkg.sv
hdl/lbas_cfg_regs.sv
hdl/lbas_adler_step.sv
hdl/line_block_adler_signer.sv
tb/tb.sv
